// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the commutator top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHECK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`define CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CHECK_SAME(lbl, ante, cons)
`define CHECK_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/hssc_pkg.sv =====
package hssc_pkg;

  localparam logic [10:0] COMPARE_TOP = 11'd2000;
  localparam logic [9:0]  DUTY_MAX    = 10'd1000;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  localparam logic [9:0]  DUTY_RESET     = 10'd100;
  localparam logic [15:0] STALL_RESET    = 16'd200;
  localparam logic [15:0] RECOVERY_RESET = 16'd1000;

  localparam logic [1:0] CFG_DUTY_LEVEL     = 2'd0;
  localparam logic [1:0] CFG_STALL_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_RECOVERY_LIMIT = 2'd2;

  localparam logic KIND_COMMUTATE = 1'b0;
  localparam logic KIND_RECHARGE  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [2:0] hall;
  } req_t;

  typedef struct packed {
    logic [10:0] compare_a;
    logic [10:0] compare_b;
    logic [10:0] compare_c;
    logic        low_on_a;
    logic        low_on_b;
    logic        low_on_c;
    logic        locked;
  } res_t;

  typedef struct packed {
    logic [9:0]  duty_level;
    logic [15:0] stall_limit;
    logic [15:0] recovery_limit;
  } cfg_t;

  // Forward six-step table: HA LA HB LB HC LC.
  function automatic logic [5:0] fwd_pattern(input logic [2:0] hall);
    logic [5:0] pat;
    case (hall)
      3'd1:    pat = 6'b100100;
      3'd2:    pat = 6'b010010;
      3'd3:    pat = 6'b000110;
      3'd4:    pat = 6'b001001;
      3'd5:    pat = 6'b100001;
      3'd6:    pat = 6'b011000;
      default: pat = 6'b000000;
    endcase
    return pat;
  endfunction

endpackage

// ===== rtl/hssc_regs.sv =====
module hssc_regs
  import hssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duty_level     <= DUTY_RESET;
      cfg.stall_limit    <= STALL_RESET;
      cfg.recovery_limit <= RECOVERY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DUTY_LEVEL:     cfg.duty_level     <= cfg_data[9:0];
        CFG_STALL_LIMIT:    cfg.stall_limit    <= cfg_data;
        CFG_RECOVERY_LIMIT: cfg.recovery_limit <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/hssc_core.sv =====
module hssc_core
  import hssc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  req_t req,
  input  cfg_t cfg,
  output res_t res_next
);

  logic [5:0]  gate_pattern, gate_pattern_next;
  logic [5:0]  previous_pattern, previous_pattern_next;
  logic [15:0] stall_count, stall_count_next;
  logic [15:0] recovery_count, recovery_count_next;
  logic        locked_flag, locked_flag_next;
  logic [2:0]  low_on, low_on_next;
  logic [10:0] cmp [3];
  logic [10:0] cmp_next [3];

  logic [5:0]  pattern;
  logic [15:0] rc_inc;
  logic [9:0]  duty_sat;
  logic [10:0] active_cmp;

  always_comb begin
    gate_pattern_next     = gate_pattern;
    previous_pattern_next = previous_pattern;
    stall_count_next      = stall_count;
    recovery_count_next   = recovery_count;
    locked_flag_next      = locked_flag;
    low_on_next           = low_on;
    for (int p = 0; p < 3; p++) cmp_next[p] = cmp[p];

    duty_sat   = (cfg.duty_level > DUTY_MAX) ? DUTY_MAX : cfg.duty_level;
    active_cmp = COMPARE_TOP - {duty_sat, 1'b0};
    rc_inc     = (recovery_count != COUNT_MAX) ? recovery_count + 16'd1 : recovery_count;
    pattern    = fwd_pattern(req.hall);

    if (req.kind == KIND_RECHARGE) begin
      for (int p = 0; p < 3; p++) begin
        if (gate_pattern[5-2*p]) begin
          cmp_next[p]    = COMPARE_TOP;
          low_on_next[p] = 1'b1;
        end
      end
    end else if (locked_flag) begin
      if (rc_inc > cfg.recovery_limit) begin
        locked_flag_next    = 1'b0;
        stall_count_next    = '0;
        recovery_count_next = '0;
      end else begin
        recovery_count_next = rc_inc;
      end
    end else begin
      if (pattern == previous_pattern) begin
        stall_count_next = (stall_count != COUNT_MAX) ? stall_count + 16'd1 : stall_count;
      end else begin
        stall_count_next = '0;
      end
      previous_pattern_next = pattern;
      if (stall_count_next > cfg.stall_limit) begin
        locked_flag_next = 1'b1;
        pattern          = '0;
      end
      gate_pattern_next = pattern;
      for (int p = 0; p < 3; p++) begin
        if (pattern[4-2*p]) begin
          cmp_next[p]    = COMPARE_TOP;
          low_on_next[p] = 1'b1;
        end else if (pattern[5-2*p]) begin
          cmp_next[p]    = active_cmp;
          low_on_next[p] = 1'b0;
        end else begin
          cmp_next[p]    = COMPARE_TOP;
          low_on_next[p] = 1'b0;
        end
      end
    end

    res_next.compare_a = cmp_next[0];
    res_next.compare_b = cmp_next[1];
    res_next.compare_c = cmp_next[2];
    res_next.low_on_a  = low_on_next[0];
    res_next.low_on_b  = low_on_next[1];
    res_next.low_on_c  = low_on_next[2];
    res_next.locked    = locked_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_pattern     <= '0;
      previous_pattern <= '0;
      stall_count      <= '0;
      recovery_count   <= '0;
      locked_flag      <= 1'b0;
      low_on           <= '0;
      for (int p = 0; p < 3; p++) cmp[p] <= COMPARE_TOP;
    end else if (adv) begin
      gate_pattern     <= gate_pattern_next;
      previous_pattern <= previous_pattern_next;
      stall_count      <= stall_count_next;
      recovery_count   <= recovery_count_next;
      locked_flag      <= locked_flag_next;
      low_on           <= low_on_next;
      for (int p = 0; p < 3; p++) cmp[p] <= cmp_next[p];
    end
  end

endmodule

// ===== rtl/hall_six_step_commutator_top.sv =====
// Six-step hall commutator. Each request is one timer tick: a commutation tick
// looks up the hall code and drives the phases, a period-end tick recharges the
// low side of every phase whose high switch is set. One request is taken per
// clock; it passes an input register, then the table lookup and counter update
// into a result register. The only thing that slows intake is a result left
// waiting at the output. Configuration writes take effect on the next cycle
// and are meant for idle.
`include "assert_macros.svh"

module hall_six_step_commutator_top
  import hssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res
);

  cfg_t cfg;
  logic s1_valid;
  req_t s1_req;
  logic adv;
  res_t res_next;

  assign adv       = s1_valid && (!res_valid || res_ready);
  assign req_ready = !s1_valid || adv;

  hssc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hssc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .req      (s1_req),
    .cfg      (cfg),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (req_ready) s1_valid <= req_valid;
      if (adv) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) s1_req <= req;
    if (adv) res <= res_next;
  end

  `CHECK_SAME(a_locked_off, res_valid && res.locked,
    !res.low_on_a && !res.low_on_b && !res.low_on_c &&
    res.compare_a == COMPARE_TOP && res.compare_b == COMPARE_TOP &&
    res.compare_c == COMPARE_TOP)
  `CHECK_SAME(a_low_no_duty, res_valid,
    (!res.low_on_a || res.compare_a == COMPARE_TOP) &&
    (!res.low_on_b || res.compare_b == COMPARE_TOP) &&
    (!res.low_on_c || res.compare_c == COMPARE_TOP))
  `CHECK_NEXT(a_stage_hold, s1_valid && !req_ready, s1_valid && $stable(s1_req))

endmodule
